// ----- src/scld_pkg.sv -----
// shared types, character codes and command word tables for the command line decoder
`timescale 1ns / 1ps
package scld_pkg;

    localparam int VALUE_W = 16;

    localparam logic [7:0] CH_NUL     = 8'd0;
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_CR      = 8'd13;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_PLUS    = 8'd43;
    localparam logic [7:0] CH_MINUS   = 8'd45;
    localparam logic [7:0] CH_ZERO    = 8'd48;
    localparam logic [7:0] CH_NINE    = 8'd57;
    localparam logic [7:0] CH_LOWER_A = 8'd97;
    localparam logic [7:0] CH_LOWER_Z = 8'd122;
    localparam logic [7:0] CASE_GAP   = 8'd32;

    // magnitude clamp: one past the largest positive value so -32768 stays reachable
    localparam logic [VALUE_W-1:0] MAG_CLAMP = 16'd32768;
    localparam logic [VALUE_W-1:0] POS_MAX   = 16'h7FFF;

    localparam int ARG_SLOTS = 3;

    typedef enum logic [2:0] {
        ST_UNKNOWN   = 3'd0,
        ST_STOP      = 3'd1,
        ST_SPEED     = 3'd2,
        ST_COLOR     = 3'd3,
        ST_SPEED_USE = 3'd4,
        ST_COLOR_USE = 3'd5,
        ST_EMPTY     = 3'd6
    } line_status_t;

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_SIGNED,
        PH_DIGITS,
        PH_DONE
    } num_phase_t;

    typedef struct packed {
        logic [7:0] rx_byte;
    } rx_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] left_speed;
        logic signed [VALUE_W-1:0] right_speed;
        logic signed [VALUE_W-1:0] led_red;
        logic signed [VALUE_W-1:0] led_green;
        logic signed [VALUE_W-1:0] led_blue;
        logic [2:0]                line_status;
        logic                      line_truncated;
    } result_item_t;

    // what the parser knows about a line when its newline arrives
    typedef struct packed {
        logic                      has_token;
        logic                      is_stop;
        logic                      is_speed;
        logic                      is_color;
        logic                      two_args;
        logic                      three_args;
        logic signed [VALUE_W-1:0] arg0;
        logic signed [VALUE_W-1:0] arg1;
        logic signed [VALUE_W-1:0] arg2;
        logic                      truncated;
    } line_summary_t;

    function automatic logic [7:0] stop_char(input logic [2:0] idx);
        logic [7:0] c;
        c = CH_NUL;
        case (idx)
            3'd0: c = "S";
            3'd1: c = "T";
            3'd2: c = "O";
            3'd3: c = "P";
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] speed_char(input logic [2:0] idx);
        logic [7:0] c;
        c = CH_NUL;
        case (idx)
            3'd0: c = "S";
            3'd1: c = "P";
            3'd2: c = "E";
            3'd3: c = "E";
            3'd4: c = "D";
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] color_char(input logic [2:0] idx);
        logic [7:0] c;
        c = CH_NUL;
        case (idx)
            3'd0: c = "C";
            3'd1: c = "O";
            3'd2: c = "L";
            3'd3: c = "O";
            3'd4: c = "R";
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

endpackage

// ----- src/scld_stream_if.sv -----
// valid/ready channel carrying one packed payload per beat
`timescale 1ns / 1ps
interface scld_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- src/serial_command_line_decoder_core.sv -----
// top level of the serial command line decoder
`timescale 1ns / 1ps
// usage:
//   rx carries one received character per beat (rx_byte); a newline closes the line
//   report carries one beat per newline: both wheel speeds, the three led values,
//   the line status and whether bytes past the line capacity were dropped
//   bytes other than newline produce no report beat
// data path and throughput:
//   a beat taken on rx is held in the input register and decoded from there; a
//   newline's report is loaded into the report register when the newline is decoded
//   one byte per cycle sustained while no newline waits on a pending report, set by
//   the single decode step between the input register and the report register
// stalls:
//   while report is held, ordinary bytes keep flowing; a second newline waits in
//   the input register until the pending report is taken, which drops rx.ready
// reset:
//   all line state, speeds and led values go to zero; the command word matcher
//   starts with all three words possible; no report is pending
module serial_command_line_decoder_core #(
    parameter int LINE_BYTES = 64,
    parameter int MAX_ARGS   = 4
) (
    input logic          clk,
    input logic          rst_n,
    scld_stream_if.sink   rx,
    scld_stream_if.source report
);
    import scld_pkg::*;

    // input register
    logic          s1_valid_reg;
    logic [7:0]    s1_byte_reg;
    logic          s1_nl;
    logic          s1_go;

    // report register
    logic          out_valid_reg;
    result_item_t  out_data_reg;

    line_summary_t summary;
    result_item_t  result_next;

    assign s1_nl = (s1_byte_reg == CH_NEWLINE);
    // only a newline needs the report register to be free
    assign s1_go = s1_valid_reg && (!s1_nl || !out_valid_reg || report.ready);
    assign rx.ready = !s1_valid_reg || s1_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (rx.valid && rx.ready)
            s1_valid_reg <= 1'b1;
        else if (s1_go)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
            s1_byte_reg <= rx.payload.rx_byte;
    end

    scld_line_parser #(
        .LINE_BYTES (LINE_BYTES),
        .MAX_ARGS   (MAX_ARGS)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (s1_go),
        .rx_byte (s1_byte_reg),
        .summary (summary)
    );

    scld_cmd_exec u_exec (
        .clk      (clk),
        .rst_n    (rst_n),
        .line_end (s1_go && s1_nl),
        .summary  (summary),
        .result   (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_go && s1_nl)
            out_valid_reg <= 1'b1;
        else if (report.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_nl)
            out_data_reg <= result_next;
    end

    assign report.valid   = out_valid_reg;
    assign report.payload = out_data_reg;

`ifndef NO_ASSERTIONS
    // a held newline keeps its place until the report slot frees up
    a_nl_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_nl && !s1_go) |=> (s1_valid_reg && $stable(s1_byte_reg)))
        else $error("held newline lost from input register");

    // ordinary bytes never wait on the report side
    a_byte_flows: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_nl) |-> s1_go)
        else $error("non-newline byte stalled");

    // a new report appears only from a decoded newline
    a_report_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_go && s1_nl))
        else $error("report raised without a newline");

    // a pending report is never overwritten by the next newline
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !report.ready) |-> !(s1_go && s1_nl))
        else $error("pending report overwritten");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.line_status != 3'd7))
        else $error("report carries an undefined status code");
`endif

endmodule

// ----- src/scld_line_parser.sv -----
// per-byte tokenizer: command word match and argument number accumulation
`timescale 1ns / 1ps
module scld_line_parser #(
    parameter int LINE_BYTES = 64,
    parameter int MAX_ARGS   = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic [7:0]             rx_byte,
    output scld_pkg::line_summary_t summary
);
    import scld_pkg::*;

    localparam int PW = $clog2(LINE_BYTES);
    localparam int TW = $clog2(MAX_ARGS + 2);
    localparam logic [PW-1:0] POS_LIMIT = PW'(LINE_BYTES - 1);
    localparam logic [TW-1:0] TOK_LIMIT = TW'(MAX_ARGS + 1);

    logic [PW-1:0]      pos_reg, pos_next;
    logic [TW-1:0]      tok_reg, tok_next;
    logic [2:0]         flags_reg, flags_next;
    logic [2:0]         wcnt_reg, wcnt_next;
    num_phase_t         phase_reg, phase_next;
    logic [VALUE_W-1:0] arg_val_reg [ARG_SLOTS];
    logic [VALUE_W-1:0] arg_val_next [ARG_SLOTS];
    logic               arg_neg_reg [ARG_SLOTS];
    logic               arg_neg_next [ARG_SLOTS];
    logic               ovf_reg, ovf_next;
    logic               in_tok_reg, in_tok_next;
    logic               ended_reg, ended_next;

    logic [7:0]         up_ch;
    logic [TW-1:0]      tok_eff;
    num_phase_t         phase_start;
    num_phase_t         phase_after;
    logic [1:0]         slot;
    logic               is_digit, is_ws, is_sign;
    logic               neg_load, val_load;
    logic [19:0]        acc_wide;
    logic [VALUE_W-1:0] acc_val;
    logic               token_byte;
    logic               word_act, arg_act;

    assign up_ch = (rx_byte >= CH_LOWER_A && rx_byte <= CH_LOWER_Z) ?
                   rx_byte - CASE_GAP : rx_byte;
    assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    assign is_ws    = (rx_byte >= CH_TAB) && (rx_byte <= CH_CR);
    assign is_sign  = (rx_byte == CH_PLUS) || (rx_byte == CH_MINUS);

    // a byte that belongs to a token (not dropped, not after a nul, not a space)
    assign token_byte = step && (rx_byte != CH_NEWLINE) && (pos_reg < POS_LIMIT) &&
                        !ended_reg && (rx_byte != CH_NUL) && (rx_byte != CH_SPACE);

    assign tok_eff = (!in_tok_reg && tok_reg < TOK_LIMIT) ? tok_reg + TW'(1) : tok_reg;
    assign phase_start = in_tok_reg ? phase_reg : PH_LEAD;
    assign slot = 2'(tok_eff - TW'(2));
    assign word_act = token_byte && (tok_eff == TW'(1));
    assign arg_act  = token_byte && (tok_eff >= TW'(2)) && (tok_eff <= TW'(4));

    // digit accumulate with clamp, x10 as two shifts
    assign acc_wide = (20'(arg_val_reg[slot]) << 3) + (20'(arg_val_reg[slot]) << 1) +
                      20'(rx_byte - CH_ZERO);
    assign acc_val  = (acc_wide > 20'(MAG_CLAMP)) ? MAG_CLAMP : acc_wide[VALUE_W-1:0];

    // number phase next state
    always_comb
    begin
        phase_after = phase_start;
        unique case (phase_start) inside
            PH_LEAD:
            begin
                if (is_ws)
                    phase_after = PH_LEAD;
                else if (is_sign)
                    phase_after = PH_SIGNED;
                else if (is_digit)
                    phase_after = PH_DIGITS;
                else
                    phase_after = PH_DONE;
            end
            PH_SIGNED, PH_DIGITS:
                phase_after = is_digit ? PH_DIGITS : PH_DONE;
            default:
                phase_after = PH_DONE;
        endcase
    end

    // number phase outputs
    always_comb
    begin
        neg_load = 1'b0;
        val_load = 1'b0;
        unique case (phase_start) inside
            PH_LEAD:
            begin
                neg_load = !is_ws && is_sign;
                val_load = !is_ws && !is_sign && is_digit;
            end
            PH_SIGNED, PH_DIGITS:
                val_load = is_digit;
            default:
            begin
                neg_load = 1'b0;
                val_load = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        pos_next    = pos_reg;
        tok_next    = tok_reg;
        flags_next  = flags_reg;
        wcnt_next   = wcnt_reg;
        phase_next  = phase_reg;
        ovf_next    = ovf_reg;
        in_tok_next = in_tok_reg;
        ended_next  = ended_reg;
        for (int i = 0; i < ARG_SLOTS; i++)
        begin
            arg_val_next[i] = arg_val_reg[i];
            arg_neg_next[i] = arg_neg_reg[i];
        end

        if (step)
        begin
            if (rx_byte == CH_NEWLINE)
            begin
                pos_next    = '0;
                tok_next    = '0;
                flags_next  = 3'b111;
                wcnt_next   = '0;
                phase_next  = PH_LEAD;
                ovf_next    = 1'b0;
                in_tok_next = 1'b0;
                ended_next  = 1'b0;
                for (int i = 0; i < ARG_SLOTS; i++)
                begin
                    arg_val_next[i] = '0;
                    arg_neg_next[i] = 1'b0;
                end
            end
            else if (pos_reg >= POS_LIMIT)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                pos_next = pos_reg + PW'(1);
                if (!ended_reg)
                begin
                    if (rx_byte == CH_NUL)
                        ended_next = 1'b1;
                    else if (rx_byte == CH_SPACE)
                        in_tok_next = 1'b0;
                    else
                    begin
                        in_tok_next = 1'b1;
                        tok_next    = tok_eff;
                        phase_next  = phase_start;
                    end
                end
            end

            if (word_act)
            begin
                if (wcnt_reg >= 3'd4 || stop_char(wcnt_reg) != up_ch)
                    flags_next[0] = 1'b0;
                if (wcnt_reg >= 3'd5 || speed_char(wcnt_reg) != up_ch)
                    flags_next[1] = 1'b0;
                if (wcnt_reg >= 3'd5 || color_char(wcnt_reg) != up_ch)
                    flags_next[2] = 1'b0;
                if (wcnt_reg < 3'd6)
                    wcnt_next = wcnt_reg + 3'd1;
            end

            if (arg_act)
            begin
                phase_next = phase_after;
                if (neg_load)
                    arg_neg_next[slot] = (rx_byte == CH_MINUS);
                if (val_load)
                    arg_val_next[slot] = acc_val;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            tok_reg    <= '0;
            flags_reg  <= 3'b111;
            wcnt_reg   <= '0;
            phase_reg  <= PH_LEAD;
            ovf_reg    <= 1'b0;
            in_tok_reg <= 1'b0;
            ended_reg  <= 1'b0;
            for (int i = 0; i < ARG_SLOTS; i++)
            begin
                arg_val_reg[i] <= '0;
                arg_neg_reg[i] <= 1'b0;
            end
        end
        else
        begin
            pos_reg    <= pos_next;
            tok_reg    <= tok_next;
            flags_reg  <= flags_next;
            wcnt_reg   <= wcnt_next;
            phase_reg  <= phase_next;
            ovf_reg    <= ovf_next;
            in_tok_reg <= in_tok_next;
            ended_reg  <= ended_next;
            for (int i = 0; i < ARG_SLOTS; i++)
            begin
                arg_val_reg[i] <= arg_val_next[i];
                arg_neg_reg[i] <= arg_neg_next[i];
            end
        end
    end

    function automatic logic [VALUE_W-1:0] signed_value(input logic [VALUE_W-1:0] mag,
                                                        input logic neg);
        logic [VALUE_W-1:0] v;
        if (neg)
            v = '0 - mag;
        else
            v = mag[VALUE_W-1] ? POS_MAX : mag;
        return v;
    endfunction

    always_comb
    begin
        summary.has_token  = (tok_reg != '0);
        summary.is_stop    = flags_reg[0] && (wcnt_reg == 3'd4);
        summary.is_speed   = flags_reg[1] && (wcnt_reg == 3'd5);
        summary.is_color   = flags_reg[2] && (wcnt_reg == 3'd5);
        summary.two_args   = (tok_reg >= TW'(3));
        summary.three_args = (tok_reg >= TW'(4));
        summary.arg0       = signed_value(arg_val_reg[0], arg_neg_reg[0]);
        summary.arg1       = signed_value(arg_val_reg[1], arg_neg_reg[1]);
        summary.arg2       = signed_value(arg_val_reg[2], arg_neg_reg[2]);
        summary.truncated  = ovf_reg;
    end

endmodule

// ----- src/scld_cmd_exec.sv -----
// command execution: speed and led value registers and line status
`timescale 1ns / 1ps
module scld_cmd_exec (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   line_end,
    input  scld_pkg::line_summary_t summary,
    output scld_pkg::result_item_t result
);
    import scld_pkg::*;

    logic signed [VALUE_W-1:0] left_reg,  left_next;
    logic signed [VALUE_W-1:0] right_reg, right_next;
    logic signed [VALUE_W-1:0] red_reg,   red_next;
    logic signed [VALUE_W-1:0] green_reg, green_next;
    logic signed [VALUE_W-1:0] blue_reg,  blue_next;
    line_status_t              status;

    always_comb
    begin
        left_next  = left_reg;
        right_next = right_reg;
        red_next   = red_reg;
        green_next = green_reg;
        blue_next  = blue_reg;
        status     = ST_UNKNOWN;
        if (!summary.has_token)
            status = ST_EMPTY;
        else if (summary.is_stop)
        begin
            left_next  = '0;
            right_next = '0;
            status     = ST_STOP;
        end
        else if (summary.is_speed)
        begin
            if (!summary.two_args)
                status = ST_SPEED_USE;
            else
            begin
                left_next  = summary.arg0;
                right_next = summary.arg1;
                status     = ST_SPEED;
            end
        end
        else if (summary.is_color)
        begin
            if (!summary.three_args)
                status = ST_COLOR_USE;
            else
            begin
                red_next   = summary.arg0;
                green_next = summary.arg1;
                blue_next  = summary.arg2;
                status     = ST_COLOR;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg  <= '0;
            right_reg <= '0;
            red_reg   <= '0;
            green_reg <= '0;
            blue_reg  <= '0;
        end
        else if (line_end)
        begin
            left_reg  <= left_next;
            right_reg <= right_next;
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    always_comb
    begin
        result.left_speed     = left_next;
        result.right_speed    = right_next;
        result.led_red        = red_next;
        result.led_green      = green_next;
        result.led_blue       = blue_next;
        result.line_status    = status;
        result.line_truncated = summary.truncated;
    end

endmodule
